// File: rtl/pir_occ_pkg.sv
// ----------------------------------------------------------------------------
// pir_occ_pkg
// Shared widths, register indexes, reset values and constants of the
// motion-sensor occupancy tracker.
// ----------------------------------------------------------------------------
package pir_occ_pkg;

  // Field and counter widths
  localparam int unsigned PERIOD_W  = 10;
  localparam int unsigned WARMUP_W  = 20;
  localparam int unsigned DEBNC_W   = 16;
  localparam int unsigned HOLD_W    = 32;
  localparam int unsigned MOTION_W  = 32;
  localparam int unsigned EVENTS_W  = 32;
  localparam int unsigned SECS_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Split of the motion timer into whole seconds and leftover milliseconds
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned SUBMS_W    = 10;
  localparam int unsigned SEC_W      = 23;

  localparam logic [SUBMS_W-1:0] SUBMS_LAST = SUBMS_W'(MS_PER_SEC - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 3'd4;

  // Register reset values
  localparam logic                RST_ACTIVE_HIGH = 1'b1;
  localparam logic [PERIOD_W-1:0] RST_SAMPLE_MS   = 10'd50;
  localparam logic [WARMUP_W-1:0] RST_WARMUP_MS   = 20'd60000;
  localparam logic [DEBNC_W-1:0]  RST_DEBOUNCE_MS = 16'd2000;
  localparam logic [HOLD_W-1:0]   RST_HOLD_MS     = 32'd300000;

  // Configuration register set
  typedef struct packed {
    logic                active_high;
    logic [PERIOD_W-1:0] sample_period_ms;
    logic [WARMUP_W-1:0] warmup_ms;
    logic [DEBNC_W-1:0]  debounce_ms;
    logic [HOLD_W-1:0]   hold_ms;
  } pir_cfg_t;

endpackage

// File: rtl/pir_occ_if.sv
// ----------------------------------------------------------------------------
// pir_occ_in_if / pir_occ_out_if
// Valid/ready channels of the occupancy tracker: sensor ticks in, status out.
// ----------------------------------------------------------------------------
interface pir_occ_in_if;
  logic valid;
  logic ready;
  logic sensor_level;

  modport source (output valid, output sensor_level, input ready);
  modport sink   (input valid, input sensor_level, output ready);
endinterface

interface pir_occ_out_if;
  logic        valid;
  logic        ready;
  logic        occupied;
  logic        warming_up;
  logic [31:0] seconds_since_motion;
  logic [31:0] motion_events;

  modport source (output valid, output occupied, output warming_up,
                  output seconds_since_motion, output motion_events, input ready);
  modport sink   (input valid, input occupied, input warming_up,
                  input seconds_since_motion, input motion_events, output ready);
endinterface

// File: rtl/pir_occupancy_tracker.sv
// ----------------------------------------------------------------------------
// pir_occupancy_tracker
// Room occupancy from a motion sensor level sampled once per sample period.
// ----------------------------------------------------------------------------
// Each request on in_chan is one millisecond tick. The block takes one tick
// per clock cycle and shows its status on out_chan in the cycle after the tick
// is accepted; an output register keeps the result while the sink stalls, and
// a new tick is still taken in the cycle the held result leaves. All timer,
// sampling, debounce and hold logic sits between the state registers and the
// output register in a single pass. Seconds since motion come from a seconds
// counter kept next to the millisecond timer, so no divider is involved. The
// user writes cfg_ port registers while no tick is in flight; not enforced.
// ----------------------------------------------------------------------------
module pir_occupancy_tracker
  import pir_occ_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pir_occ_in_if.sink           in_chan,
  pir_occ_out_if.source        out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  // Configuration
  pir_cfg_t cfg_r;

  // Tracker state
  logic [WARMUP_W-1:0] ms_reset_r,  ms_reset_nxt;
  logic [PERIOD_W-1:0] ms_sample_r, ms_sample_nxt;
  logic                prev_level_r, prev_level_nxt;
  logic                seen_r,       seen_nxt;
  logic [MOTION_W-1:0] ms_motion_r, ms_motion_nxt;
  logic [SUBMS_W-1:0]  sub_ms_r,    sub_ms_nxt;
  logic [SEC_W-1:0]    secs_r,      secs_nxt;
  logic [EVENTS_W-1:0] events_r,    events_nxt;

  // Output register
  logic                out_valid_r;
  logic                occupied_r;
  logic                warming_r;
  logic [SECS_W-1:0]   seconds_r, seconds_nxt;

  // Intermediate terms
  logic [WARMUP_W-1:0] reset_inc;
  logic [PERIOD_W-1:0] sample_inc;
  logic [MOTION_W-1:0] motion_inc;
  logic [SUBMS_W-1:0]  sub_inc;
  logic [SEC_W-1:0]    secs_inc;
  logic                motion_sat;
  logic                warming;
  logic                do_sample;
  logic                active;
  logic                take_sample;
  logic                hit;
  logic                new_event;
  logic                occupied_nxt;
  logic                in_accept;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_high      <= RST_ACTIVE_HIGH;
      cfg_r.sample_period_ms <= RST_SAMPLE_MS;
      cfg_r.warmup_ms        <= RST_WARMUP_MS;
      cfg_r.debounce_ms      <= RST_DEBOUNCE_MS;
      cfg_r.hold_ms          <= RST_HOLD_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_HIGH: cfg_r.active_high      <= cfg_wdata[0];
        REG_SAMPLE_MS:   cfg_r.sample_period_ms <= cfg_wdata[PERIOD_W-1:0];
        REG_WARMUP_MS:   cfg_r.warmup_ms        <= cfg_wdata[WARMUP_W-1:0];
        REG_DEBOUNCE_MS: cfg_r.debounce_ms      <= cfg_wdata[DEBNC_W-1:0];
        REG_HOLD_MS:     cfg_r.hold_ms          <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance timers, sample the sensor and form the status of this tick
  always_comb begin
    reset_inc  = (&ms_reset_r)  ? ms_reset_r  : ms_reset_r + 1'b1;
    sample_inc = (&ms_sample_r) ? ms_sample_r : ms_sample_r + 1'b1;
    motion_sat = &ms_motion_r;
    motion_inc = motion_sat ? ms_motion_r : ms_motion_r + 1'b1;

    // Seconds counter follows the millisecond timer, including saturation
    sub_inc  = sub_ms_r;
    secs_inc = secs_r;
    if (!motion_sat) begin
      if (sub_ms_r == SUBMS_LAST) begin
        sub_inc  = '0;
        secs_inc = secs_r + 1'b1;
      end else begin
        sub_inc = sub_ms_r + 1'b1;
      end
    end

    warming     = reset_inc < cfg_r.warmup_ms;
    do_sample   = sample_inc >= cfg_r.sample_period_ms;
    active      = in_chan.sensor_level == cfg_r.active_high;
    take_sample = do_sample && !warming;
    hit         = take_sample && active;
    new_event   = hit && !prev_level_r &&
                  (motion_inc > {{(MOTION_W-DEBNC_W){1'b0}}, cfg_r.debounce_ms});

    ms_reset_nxt   = reset_inc;
    ms_sample_nxt  = do_sample ? '0 : sample_inc;
    prev_level_nxt = take_sample ? active : prev_level_r;
    seen_nxt       = seen_r || hit;
    ms_motion_nxt  = hit ? '0 : motion_inc;
    sub_ms_nxt     = hit ? '0 : sub_inc;
    secs_nxt       = hit ? '0 : secs_inc;
    events_nxt     = events_r + {{(EVENTS_W-1){1'b0}}, new_event};

    occupied_nxt = seen_nxt && (ms_motion_nxt < cfg_r.hold_ms);
    seconds_nxt  = seen_nxt ? {{(SECS_W-SEC_W){1'b0}}, secs_nxt} : '1;
  end

  // Hold tracker state; advance on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_reset_r   <= '0;
      ms_sample_r  <= '0;
      prev_level_r <= 1'b0;
      seen_r       <= 1'b0;
      ms_motion_r  <= '0;
      sub_ms_r     <= '0;
      secs_r       <= '0;
      events_r     <= '0;
    end else if (in_accept) begin
      ms_reset_r   <= ms_reset_nxt;
      ms_sample_r  <= ms_sample_nxt;
      prev_level_r <= prev_level_nxt;
      seen_r       <= seen_nxt;
      ms_motion_r  <= ms_motion_nxt;
      sub_ms_r     <= sub_ms_nxt;
      secs_r       <= secs_nxt;
      events_r     <= events_nxt;
    end
  end

  // Output valid: set on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      occupied_r <= occupied_nxt;
      warming_r  <= warming;
      seconds_r  <= seconds_nxt;
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.occupied             = occupied_r;
  assign out_chan.warming_up           = warming_r;
  assign out_chan.seconds_since_motion = seconds_r;
  assign out_chan.motion_events        = events_r;

endmodule

// File: rtl/pir_occ_checker.sv
// ----------------------------------------------------------------------------
// pir_occ_checker
// Port-level checks of the occupancy tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pir_occ_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        occupied,
  input logic        warming_up,
  input logic [31:0] seconds_since_motion,
  input logic [31:0] motion_events
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(occupied) &&
    $stable(warming_up) && $stable(seconds_since_motion) && $stable(motion_events))
    else $error("stalled result changed or dropped");

  // Stall the input only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // Each accepted tick gives a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick gave no result");

  // Occupied implies motion was seen
  a_occ_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && occupied |-> seconds_since_motion != 32'hFFFF_FFFF)
    else $error("occupied without any motion seen");

endmodule

bind pir_occupancy_tracker pir_occ_checker u_pir_occ_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_chan.valid),
  .in_ready             (in_chan.ready),
  .out_valid            (out_chan.valid),
  .out_ready            (out_chan.ready),
  .occupied             (out_chan.occupied),
  .warming_up           (out_chan.warming_up),
  .seconds_since_motion (out_chan.seconds_since_motion),
  .motion_events        (out_chan.motion_events)
);
